FILE: rtl/pwtm_pkg.sv
// Shared constants, types, key increments and the sequencer program of the wavetable mixer.
`timescale 1ns / 1ps

package pwtm_pkg;

   // Fixed geometry
   localparam int TABLE_SIZE      = 2048;
   localparam int NUM_VOICES      = 16;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int SAMPLE_BITS     = 12;
   localparam int GAIN_W          = 16;
   localparam int STEP_W          = 24;

   localparam int ADDR_W  = $clog2(TABLE_SIZE);
   localparam int PHASE_W = ADDR_W + PHASE_FRAC_BITS;
   localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(NUM_VOICES + 1);

   localparam logic [GAIN_W-1:0]      GAIN_RESET = 16'd3277;
   localparam logic [SAMPLE_BITS-1:0] SAT_MAX    = {SAMPLE_BITS{1'b1}};

   // Key pitches in units of 1e-4 Hz, sample rate 46875 Hz
   localparam longint unsigned STEP_DEN = 64'd46875 * 64'd10000;

   localparam longint unsigned KEY_PITCH_E4 [16] = '{
      64'd2200000, 64'd2330819, 64'd2469417, 64'd2616256,
      64'd2771826, 64'd2936648, 64'd3111270, 64'd3296276,
      64'd3492282, 64'd3699944, 64'd3919954, 64'd4153047,
      64'd4400000, 64'd4661638, 64'd4938833, 64'd5232511
   };

   // Phase increment, rounded half up; evaluated at elaboration only
   function automatic logic [STEP_W-1:0] step_calc(longint unsigned pitch);
      return STEP_W'((((pitch * longint'(TABLE_SIZE)) << PHASE_FRAC_BITS)
                      + STEP_DEN / 2) / STEP_DEN);
   endfunction

   localparam logic [STEP_W-1:0] PHASE_STEP [NUM_VOICES] = '{
      step_calc(KEY_PITCH_E4[0]),  step_calc(KEY_PITCH_E4[1]),
      step_calc(KEY_PITCH_E4[2]),  step_calc(KEY_PITCH_E4[3]),
      step_calc(KEY_PITCH_E4[4]),  step_calc(KEY_PITCH_E4[5]),
      step_calc(KEY_PITCH_E4[6]),  step_calc(KEY_PITCH_E4[7]),
      step_calc(KEY_PITCH_E4[8]),  step_calc(KEY_PITCH_E4[9]),
      step_calc(KEY_PITCH_E4[10]), step_calc(KEY_PITCH_E4[11]),
      step_calc(KEY_PITCH_E4[12]), step_calc(KEY_PITCH_E4[13]),
      step_calc(KEY_PITCH_E4[14]), step_calc(KEY_PITCH_E4[15])
   };

   // Program steps
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_READ   = 3'd1;
   localparam step_type STEP_INTERP = 3'd2;
   localparam step_type STEP_GAIN   = 3'd3;
   localparam step_type STEP_ACC    = 3'd4;
   localparam step_type STEP_EMIT   = 3'd5;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_TICK,
      COND_NOT_HELD,
      COND_NOT_LAST,
      COND_FREE
   } cond_type;

   typedef struct packed {
      logic     ready;      // take an input transfer
      logic     rd_en;      // read both neighbor entries
      logic     interp_en;  // register interpolated sample
      logic     gain_en;    // register scaled sample
      logic     acc_en;     // accumulate, step phase, next voice
      logic     out_en;     // load result register
      logic     hold;       // stay on this step when the jump is not taken
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic tick;   // tick transfer this cycle
      logic held;   // current voice held
      logic last;   // current voice is the last one
      logic free;   // result register can take a value
   } status_type;

   typedef struct packed {
      logic held;
      logic last;
   } dp_status_type;

   // Control store
   function automatic ctrl_type ucode(step_type step);
      ctrl_type w;
      w = '0;
      w.cond   = COND_NEVER;
      w.target = STEP_WAIT;
      case (step)
         STEP_WAIT: begin
            w.ready  = 1'b1;
            w.hold   = 1'b1;
            w.cond   = COND_TICK;
            w.target = STEP_READ;
         end
         STEP_READ: begin
            w.rd_en  = 1'b1;
            w.cond   = COND_NOT_HELD;
            w.target = STEP_ACC;
         end
         STEP_INTERP: begin
            w.interp_en = 1'b1;
         end
         STEP_GAIN: begin
            w.gain_en = 1'b1;
         end
         STEP_ACC: begin
            w.acc_en = 1'b1;
            w.cond   = COND_NOT_LAST;
            w.target = STEP_READ;
         end
         STEP_EMIT: begin
            w.out_en = 1'b1;
            w.hold   = 1'b1;
            w.cond   = COND_FREE;
            w.target = STEP_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/pwtm_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module pwtm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

FILE: rtl/pwtm_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module pwtm_seq
   import pwtm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type step_ff, step_in;
   logic     jump;

   assign ctrl = ucode(step_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_TICK:     jump = status.tick;
         COND_NOT_HELD: jump = ~status.held;
         COND_NOT_LAST: jump = ~status.last;
         COND_FREE:     jump = status.free;
         default:       jump = 1'b0;
      endcase
      if (jump) begin
         step_in = ctrl.target;
      end else if (ctrl.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_type'(step_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/pwtm_dp.sv
// Voice datapath: phases, interpolation, gain multiply and mix accumulator.
`timescale 1ns / 1ps

module pwtm_dp
   import pwtm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic                   start,
   input  logic [NUM_VOICES-1:0]  start_mask,
   input  logic [GAIN_W-1:0]      gain,
   input  logic [SAMPLE_BITS-1:0] rd_data_a,
   input  logic [SAMPLE_BITS-1:0] rd_data_b,
   output logic [ADDR_W-1:0]      rd_addr_a,
   output logic [ADDR_W-1:0]      rd_addr_b,
   output dp_status_type          dp_status,
   output logic [SUM_W-1:0]       sum
);

   localparam int PROD_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
   localparam int GPROD_W = SAMPLE_BITS + GAIN_W;

   logic [VOICE_W-1:0]     voice_ff, voice_in;
   logic [PHASE_W-1:0]     phase_ff [NUM_VOICES];
   logic [NUM_VOICES-1:0]  mask_ff;
   logic [SAMPLE_BITS-1:0] interp_ff, interp_in;
   logic [SAMPLE_BITS-1:0] contrib_ff, contrib_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic [PHASE_W-1:0]         phase_cur, phase_in;
   logic [PHASE_FRAC_BITS-1:0] frac;
   logic                       held;
   logic signed [SAMPLE_BITS:0] diff, ramp, interp_full;
   logic signed [PROD_W-1:0]   prod, prod_sh;
   logic [GPROD_W-1:0]         gprod;

   always_comb begin
      phase_cur = phase_ff[voice_ff];
      held      = mask_ff[voice_ff];
      frac      = phase_cur[PHASE_FRAC_BITS-1:0];
      rd_addr_a = phase_cur[PHASE_W-1 -: ADDR_W];
      rd_addr_b = ADDR_W'(rd_addr_a + 1'b1);   // wraps to entry 0

      // (a*(1-f) + b*f) >> F  ==  a + floor((b-a)*f / 2^F)
      diff        = $signed({1'b0, rd_data_b}) - $signed({1'b0, rd_data_a});
      prod        = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
      prod_sh     = prod >>> PHASE_FRAC_BITS;
      ramp        = $signed(prod_sh[SAMPLE_BITS:0]);
      interp_full = $signed({1'b0, rd_data_a}) + ramp;
      interp_in   = interp_full[SAMPLE_BITS-1:0];

      gprod      = GPROD_W'(interp_ff) * GPROD_W'(gain);
      contrib_in = gprod[GPROD_W-1 -: SAMPLE_BITS];

      sum_in   = sum_ff + (held ? SUM_W'(contrib_ff) : SUM_W'(0));
      phase_in = held ? PHASE_W'(phase_cur + PHASE_W'(PHASE_STEP[voice_ff])) : '0;
      voice_in = VOICE_W'(voice_ff + 1'b1);
   end

   assign dp_status.held = held;
   assign dp_status.last = (voice_ff == VOICE_W'(NUM_VOICES - 1));
   assign sum            = sum_ff;

   // Control state: voice pointer and phases
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= '0;
         for (int k = 0; k < NUM_VOICES; k++) begin
            phase_ff[k] <= '0;
         end
      end else if (start) begin
         voice_ff <= '0;
      end else if (ctrl.acc_en) begin
         phase_ff[voice_ff] <= phase_in;
         voice_ff           <= voice_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (start) begin
         mask_ff <= start_mask;
         sum_ff  <= '0;
      end else if (ctrl.acc_en) begin
         sum_ff <= sum_in;
      end
      if (ctrl.interp_en) begin
         interp_ff <= interp_in;
      end
      if (ctrl.gain_en) begin
         contrib_ff <= contrib_in;
      end
   end

endmodule

FILE: rtl/polyphonic_wavetable_mixer.sv
// Top level of the polyphonic wavetable mixer: channels, gain register, result register.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Transfer when
// req_*     in   tdata: table_address, table_value, key_mask      req_tvalid & req_tready
//                tuser: command (0 table write, 1 tick)
// rsp_*     out  tdata: mixed_sample; tuser: clipped              rsp_tvalid & rsp_tready
// csr_*     in   csr_data: voice_gain                              csr_valid & csr_ready
//
// A table write is taken in the wait step. A tick runs a microprogram loop over voices
// through one dual-read table port and one shared multiply pair: read, interpolate, gain
// and accumulate for a held key, read and accumulate for a released key, then emit.
// Reset is synchronous, active high; the wave table is not cleared, phases are.
// A finished result waits in the output register; the next item is taken while it
// waits, and only the next result's load stalls until the consumer takes the first.

module polyphonic_wavetable_mixer
   import pwtm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [10:0] table_address, [22:11] table_value,
                                    // [38:23] key_mask, [39] zero
   input  logic        req_tuser,   // [0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] mixed_sample, [15:12] zero
   output logic        rsp_tuser,   // [0] clipped
   // gain register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // voice_gain
);

   ctrl_type      ctrl;
   status_type    status;
   dp_status_type dp_status;

   logic [GAIN_W-1:0]      gain_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_clip_ff;

   logic [ADDR_W-1:0]      wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic [NUM_VOICES-1:0]  key_mask;
   logic                   req_xfer, wr_en, load;
   logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
   logic [SAMPLE_BITS-1:0] rd_data_a, rd_data_b;
   logic [SUM_W-1:0]       sum;
   logic                   over;

   // Unpack the request
   assign wr_addr  = req_tdata[10:0];
   assign wr_data  = req_tdata[22:11];
   assign key_mask = req_tdata[38:23];

   assign req_tready = ctrl.ready;
   assign req_xfer   = req_tvalid & req_tready;
   // address field spans the whole table, so every write lands
   assign wr_en      = req_xfer & ~req_tuser;

   assign status.tick = req_xfer & req_tuser;
   assign status.held = dp_status.held;
   assign status.last = dp_status.last;
   assign status.free = ~rsp_valid_ff | rsp_tready;

   pwtm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   pwtm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_wave (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (ctrl.rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   pwtm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .start      (status.tick),
      .start_mask (key_mask),
      .gain       (gain_ff),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .dp_status  (dp_status),
      .sum        (sum)
   );

   // Saturating output stage
   assign over         = (sum > SUM_W'(SAT_MAX));
   assign load         = ctrl.out_en & status.free;
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            gain_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_sample_ff <= over ? SAT_MAX : sum[SAMPLE_BITS-1:0];
         rsp_clip_ff   <= over;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_sample_ff};
   assign rsp_tuser  = rsp_clip_ff;

`ifndef SYNTH
   // A tick transfer starts the voice loop with a table read
   a_tick_starts_loop: assert property (@(posedge clock) disable iff (reset)
      status.tick |=> ctrl.rd_en)
      else $error("tick transfer not followed by voice read");

   // The clip flag comes only with a full-scale sample
   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[SAMPLE_BITS-1:0] == SAT_MAX))
      else $error("clipped result without saturated sample");

   // A new result appears only from the emit step
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.out_en))
      else $error("result valid raised outside emit step");
`endif

endmodule
